@@ design/sidau_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII unit.
// Used by the front, queue, back and top-level modules; no dependencies.
package sidau_pkg;

	// Default and largest supported number of decimal digits.
	localparam int DIGIT_COUNT_DEF = 10;
	localparam int MAX_DIGITS      = 19;

	// Digit index width, wide enough for every supported digit count.
	localparam int IDX_W = $clog2(MAX_DIGITS + 1);

	// Magnitude conversion: 32-bit input, ten BCD digits, four bits per cycle.
	localparam int MAG_W        = 32;
	localparam int BCD_DIGITS   = 10;
	localparam int BCD_W        = 4 * BCD_DIGITS;
	localparam int BITS_PER_CYC = 4;
	localparam int CONV_STEPS   = MAG_W / BITS_PER_CYC;
	localparam int STEP_CNT_W   = $clog2(CONV_STEPS);

	// ASCII codes.
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_COMMA = 8'd44;
	localparam logic [7:0] CH_MINUS = 8'd45;

	// Per-number control information passed from the front to the back.
	typedef struct packed {
		logic             neg;
		logic             has_comma;
		logic             start_comma;
		logic [IDX_W-1:0] comma_idx;
		logic [IDX_W-1:0] start_idx;
	} conv_ctrl_t;

	// One double-dabble step: correct every digit, then shift in one bit.
	function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
			input logic in_bit);
		logic [BCD_W-1:0] fixed;
		fixed = bcd;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (fixed[i*4 +: 4] >= 4'd5) begin
				fixed[i*4 +: 4] = fixed[i*4 +: 4] + 4'd3;
			end
		end
		return {fixed[BCD_W-2:0], in_bit};
	endfunction

endpackage

@@ design/signed_int_to_decimal_ascii_unit.sv @@
// Signed integer to decimal ASCII converter.
// A request carries a signed 32-bit value and a count of decimal places. The
// result channel returns the number as ASCII characters, one per transfer,
// most significant first: an optional minus sign, the digits with leading
// zeros removed (the units digit is always kept), and a comma before the last
// 'decimals' digits when decimals is between 1 and DIGIT_COUNT-1. last_char
// marks the final character of each number.
// Both channels transfer when valid is high and stall is low.
// Timing: the front converts the magnitude with a double-dabble unit that
// handles four bits per cycle, and it takes a new request only while idle or
// while the finished one is handed to the queue. The back emits one
// character per cycle while the receiver does not stall; a number has at
// most DIGIT_COUNT+2 characters.
// A two-entry queue lets the front take new requests while the back is still
// emitting. When the receiver stalls, the output register holds its character
// and the queue fills, after which in_stall rises. Reset clears all control
// state; no characters are pending after reset.
module signed_int_to_decimal_ascii_unit import sidau_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [31:0] value,
	input  logic [3:0]        decimals,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        character,
	output logic              last_char
);

	localparam int DIG_W  = 4 * DIGIT_COUNT;
	localparam int DATA_W = $bits(conv_ctrl_t) + DIG_W;

	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	conv_ctrl_t        f_ctrl;
	logic [DIG_W-1:0]  f_digits;
	logic [DATA_W-1:0] q_out;
	conv_ctrl_t        b_ctrl;
	logic [DIG_W-1:0]  b_digits;

	// Conversion and classification.
	sidau_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.decimals (decimals),
		.q_full   (q_full),
		.push     (q_push),
		.ctrl     (f_ctrl),
		.digits   (f_digits)
	);

	// Decoupling queue.
	sidau_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_ctrl, f_digits}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign b_ctrl   = q_out[DATA_W-1 -: $bits(conv_ctrl_t)];
	assign b_digits = q_out[DIG_W-1:0];

	// Character sequencer.
	sidau_back #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_ctrl    (b_ctrl),
		.q_digits  (b_digits),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last_char (last_char)
	);

endmodule

@@ design/sidau_front.sv @@
// Front end: accepts requests, converts the magnitude to BCD and classifies
// the digit string (start position, comma place). Depends on sidau_pkg.
module sidau_front import sidau_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [31:0]       value,
	input  logic [3:0]               decimals,
	input  logic                     q_full,
	output logic                     push,
	output conv_ctrl_t               ctrl,
	output logic [4*DIGIT_COUNT-1:0] digits
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_DONE = 3'b100
	} front_state_t;

	front_state_t          state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0]      mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  neg_q;
	logic [3:0]            dec_q;

	logic                  accept;
	logic [MAG_W-1:0]      mag_in;
	logic [BCD_W-1:0]      bcd_next;
	logic [IDX_W-1:0]      first_nz;
	logic [IDX_W-1:0]      comma_idx;
	logic                  has_comma;
	logic                  start_comma;

	// A new request is taken when idle, or while the finished one is pushed.
	assign in_stall = !((state_q == F_IDLE) || ((state_q == F_DONE) && !q_full));
	assign accept   = in_valid && !in_stall;
	assign push     = (state_q == F_DONE) && !q_full;

	// Magnitude of the two's complement input.
	assign mag_in = value[MAG_W-1] ? (~value + 32'd1) : value;

	// Four double-dabble steps per cycle.
	always_comb begin
		bcd_next = bcd_q;
		for (int s = 0; s < BITS_PER_CYC; s++) begin
			bcd_next = dabble_step(bcd_next, mag_q[MAG_W-1-s]);
		end
	end

	// Map BCD digits to the output digit string; weight 10^i sits at nibble i.
	always_comb begin
		digits = '0;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (i < BCD_DIGITS) begin
				digits[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Find the first nonzero digit; the units digit is the fallback.
	always_comb begin
		first_nz = IDX_W'(DIGIT_COUNT - 1);
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (digits[i*4 +: 4] != 4'd0) begin
				first_nz = IDX_W'(DIGIT_COUNT - 1 - i);
			end
		end
	end

	// The comma follows digit comma_idx when decimals is within range.
	assign has_comma   = (dec_q != 4'd0) && (IDX_W'(dec_q) < IDX_W'(DIGIT_COUNT));
	assign comma_idx   = IDX_W'(DIGIT_COUNT - 1) - IDX_W'(dec_q);
	assign start_comma = has_comma && (first_nz > comma_idx);

	always_comb begin
		ctrl.neg         = neg_q;
		ctrl.has_comma   = has_comma;
		ctrl.start_comma = start_comma;
		ctrl.comma_idx   = comma_idx;
		ctrl.start_idx   = start_comma ? (comma_idx + IDX_W'(1)) : first_nz;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
						cnt_q   <= '0;
					end
				end
				F_CONV: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (cnt_q == STEP_CNT_W'(CONV_STEPS - 1)) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (accept) begin
						state_q <= F_CONV;
						cnt_q   <= '0;
					end else if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	// Conversion datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag_in;
			bcd_q <= '0;
			neg_q <= value[MAG_W-1];
			dec_q <= decimals;
		end else if (state_q == F_CONV) begin
			mag_q <= {mag_q[MAG_W-BITS_PER_CYC-1:0], {BITS_PER_CYC{1'b0}}};
			bcd_q <= bcd_next;
		end
	end

endmodule

@@ design/sidau_queue.sv @@
// Two-entry queue between the front and the back of the converter.
// Holds packed control and digit data; depends on sidau_pkg.
module sidau_queue import sidau_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// The front only pushes into free space and the back only pops filled entries.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

@@ design/sidau_back.sv @@
// Back end: walks the digit string of one queued number and emits the sign, digits
// and comma into an output register, one per cycle unless stalled. Uses sidau_pkg.
module sidau_back import sidau_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	input  conv_ctrl_t               q_ctrl,
	input  logic [4*DIGIT_COUNT-1:0] q_digits,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [7:0]               character,
	output logic                     last_char
);

	localparam int SR_W = 4 * DIGIT_COUNT;

	logic             active_q;
	logic             minus_q;
	logic             comma_q;
	logic             has_comma_q;
	logic [IDX_W-1:0] comma_idx_q;
	logic [IDX_W-1:0] j_q;
	logic [SR_W-1:0]  sr_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             advance;
	logic             emit_digit;
	logic             emit_last;
	logic             load;

	assign out_valid = valid_q;
	assign character = char_q;
	assign last_char = last_q;

	// The output register takes a new character when empty or being drained.
	assign advance    = !valid_q || !out_stall;
	assign emit_digit = active_q && !minus_q && !comma_q;
	assign emit_last  = emit_digit && (j_q == IDX_W'(DIGIT_COUNT - 1));
	assign load       = advance && (!active_q || emit_last) && !q_empty;
	assign q_pop      = load;

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			minus_q  <= 1'b0;
			comma_q  <= 1'b0;
			valid_q  <= 1'b0;
		end else if (advance) begin
			valid_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				minus_q  <= q_ctrl.neg;
				comma_q  <= q_ctrl.start_comma;
			end else if (active_q) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else if (comma_q) begin
					comma_q <= 1'b0;
				end else if (emit_last) begin
					active_q <= 1'b0;
				end else if (has_comma_q && (j_q == comma_idx_q)) begin
					comma_q <= 1'b1;
				end
			end
		end
	end

	// Digit string, position and output character.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (active_q) begin
				if (minus_q) begin
					char_q <= CH_MINUS;
					last_q <= 1'b0;
				end else if (comma_q) begin
					char_q <= CH_COMMA;
					last_q <= 1'b0;
				end else begin
					char_q <= CH_ZERO + {4'd0, sr_q[SR_W-1 -: 4]};
					last_q <= emit_last;
				end
			end
			if (load) begin
				has_comma_q <= q_ctrl.has_comma;
				comma_idx_q <= q_ctrl.comma_idx;
				j_q         <= q_ctrl.start_idx;
				sr_q        <= q_digits << {q_ctrl.start_idx, 2'b00};
			end else if (emit_digit) begin
				j_q  <= j_q + IDX_W'(1);
				sr_q <= {sr_q[SR_W-5:0], 4'd0};
			end
		end
	end

	// Only a digit may close a number. A comma can be pending beside the sign
	// only when the number opens with the comma.
	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && last_q) |-> (char_q >= CH_ZERO && char_q <= CH_ZERO + 8'd9))
		else $error("last character is not a digit");
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && minus_q && comma_q) |-> (j_q == comma_idx_q + IDX_W'(1)))
		else $error("comma pending together with sign away from the start");

endmodule
